// ===== rtl/core/tcsl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcsl_pkg
// Shared types, constants and fixed-point helpers of the throttle current and
// speed limiter.
// ----------------------------------------------------------------------------
package tcsl_pkg;

	// Default sample width; full throttle is 2^(SAMPLE_BITS-1) sample units.
	localparam int SAMPLE_BITS_DEF = 12;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Result item: 34 field bits padded to whole bytes
	localparam int OUT_FIELD_W = 34;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

	// Divider: 32 quotient bits, a few per cycle
	localparam int DIV_Q_W     = 32;
	localparam int DIV_BPC     = 2;
	localparam int DIV_CYCLES  = DIV_Q_W / DIV_BPC;
	localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

	// Register reset values
	localparam logic [15:0] RST_SMOOTHING_WEIGHT = 16'd13107;
	localparam logic [11:0] RST_DEADBAND         = 12'd205;
	localparam logic [15:0] RST_FULL_SCALE_RPM   = 16'd10000;
	localparam logic [15:0] RST_FULL_SCALE_CUR   = 16'd10000;
	localparam logic [15:0] RST_SPEED_FRACTION   = 16'd58982;
	localparam logic [15:0] RST_INTEGRAL_GAIN    = 16'd655;

	localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SMOOTHING_WEIGHT     = 3'd0,
		CFG_DEADBAND             = 3'd1,
		CFG_FULL_SCALE_RPM       = 3'd2,
		CFG_FULL_SCALE_CURRENT   = 3'd3,
		CFG_SPEED_LIMIT_FRACTION = 3'd4,
		CFG_INTEGRAL_GAIN        = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_AVG,
		S_AVG,
		S_P1,
		S_P3,
		S_DECIDE,
		S_DEAD,
		S_LIM_MUL,
		S_LIM_DONE,
		S_DIV_LOAD,
		S_DIV,
		S_ADJ,
		S_GAIN_MUL,
		S_VEL_DONE,
		S_FINISH
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_AVG,
		OP_AVG,
		OP_P1,
		OP_P3,
		OP_DECIDE,
		OP_DEAD,
		OP_LIM_MUL,
		OP_LIM_DONE,
		OP_DIV_LOAD,
		OP_DIV_STEP,
		OP_ADJ,
		OP_GAIN_MUL,
		OP_VEL_DONE,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic dead;   // smoothed throttle inside the deadband
		logic vel;    // speed correction applies
	} dp_status_t;

	// Packed so that motor_enable lands in the lowest bit
	typedef struct packed {
		logic signed [15:0] held_current_ma;
		logic               velocity_mode;
		logic signed [15:0] drive_current_ma;
		logic               motor_enable;
	} tcsl_result_t;

	// Shift right by sh, round to nearest, ties away from zero
	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
			input int sh);
		logic [63:0] mag;
		mag = v[63] ? 64'(-v) : 64'(v);
		mag = (mag + (64'd1 << (sh - 1))) >> sh;
		return v[63] ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'(INT32_MAX)) begin
			return INT32_MAX;
		end else if (v < 64'(INT32_MIN)) begin
			return INT32_MIN;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -64'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

endpackage

// ===== rtl/core/tcsl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcsl_ctrl
// Sequencer of the limiter: walks one tick through the shared multiplier and
// the divider, and owns the input and result handshakes.
// ----------------------------------------------------------------------------
module tcsl_ctrl
	import tcsl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_sample_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	ctrl_state_t          state_q, state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;
	logic                 out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV_LOAD) begin
				div_cnt_q <= '0;
			end else if (state_q == S_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					// a failed read leaves the stored state as it was
					if (in_sample_valid) begin
						state_d = S_MUL_AVG;
					end
				end
			end
			S_MUL_AVG: begin
				cmd.op  = OP_MUL_AVG;
				state_d = S_AVG;
			end
			S_AVG: begin
				cmd.op  = OP_AVG;
				state_d = S_P1;
			end
			S_P1: begin
				cmd.op  = OP_P1;
				state_d = status.dead ? S_DEAD : S_P3;
			end
			S_P3: begin
				cmd.op  = OP_P3;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.op  = OP_DECIDE;
				state_d = status.vel ? S_DIV_LOAD : S_LIM_MUL;
			end
			S_DEAD: begin
				cmd.op  = OP_DEAD;
				state_d = S_FINISH;
			end
			S_LIM_MUL: begin
				cmd.op  = OP_LIM_MUL;
				state_d = S_LIM_DONE;
			end
			S_LIM_DONE: begin
				cmd.op  = OP_LIM_DONE;
				state_d = S_FINISH;
			end
			S_DIV_LOAD: begin
				cmd.op  = OP_DIV_LOAD;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (div_cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
					state_d = S_ADJ;
				end
			end
			S_ADJ: begin
				cmd.op  = OP_ADJ;
				state_d = S_GAIN_MUL;
			end
			S_GAIN_MUL: begin
				cmd.op  = OP_GAIN_MUL;
				state_d = S_VEL_DONE;
			end
			S_VEL_DONE: begin
				cmd.op  = OP_VEL_DONE;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				// hold until the result register is free
				if (!out_valid_q || out_ready) begin
					cmd.op   = OP_FINISH;
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/tcsl_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcsl_dp
// Datapath of the limiter: configuration registers, state, one shared
// registered multiplier, a radix-4 divider and the result register.
// ----------------------------------------------------------------------------
module tcsl_dp
	import tcsl_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dp_cmd_t                       cmd,
	output dp_status_t                    status,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic signed [SAMPLE_BITS-1:0] throttle_sample,
	input  logic signed [15:0]            motor_rpm,
	output tcsl_result_t                  result
);

	localparam int SW     = SAMPLE_BITS;
	localparam int AvgW   = SW + 8;
	localparam int P1W    = SW + 17;
	localparam int P2W    = SW + 33;
	localparam int P3W    = SW + 17;
	localparam int ErrW   = SW + 18;
	localparam int Lim8W  = 26;
	localparam int CmpW   = SW + 36;
	localparam int MulAW  = (SW + 18 > 34) ? SW + 18 : 34;
	localparam int MulBW  = 17;
	localparam int ProdW  = MulAW + MulBW;
	localparam int SumW   = ProdW + 9;
	localparam int NpW    = SumW - SW + 1;

	// configuration
	logic [15:0] w_q, frs_q, fcu_q, frac_q, gain_q;
	logic [11:0] db_q;

	// state
	logic signed [AvgW-1:0]  avg_q;
	logic signed [31:0]      cur_q;

	// working registers
	logic signed [SW-1:0]    s_q;
	logic signed [15:0]      rpm_q;
	logic signed [ProdW-1:0] prod_q;
	logic signed [P1W-1:0]   p1_q;
	logic signed [P2W-1:0]   p2_q;
	logic signed [Lim8W-1:0] lim8_q;
	logic signed [31:0]      adj_q;
	logic                    vel_q, en_q, neg_q, ovf_q;
	logic [15:0]             rem_q;
	logic [DIV_Q_W-1:0]      quo_q;
	tcsl_result_t            res_q;

	// combinational
	logic signed [AvgW-1:0]  s8;
	logic signed [AvgW:0]    diff;
	logic [SW:0]             abs_s;
	logic [AvgW:0]           abs_avg;
	logic                    brake;
	logic signed [63:0]      avg_rnd;
	logic signed [AvgW-1:0]  avg_new;
	logic                    pos;
	logic signed [ErrW-1:0]  err;
	logic signed [CmpW-1:0]  rpm_sh, p2x, cur_sh, p3_sh;
	logic                    vel_c;
	logic signed [63:0]      lim8_w;
	logic signed [MulAW-1:0] lim_diff;
	logic signed [MulAW-1:0] mul_a;
	logic signed [MulBW-1:0] mul_b;
	logic                    mul_en;
	logic signed [ProdW-1:0] mul_p;
	logic [ProdW-1:0]        abs_prod;
	logic [15:0]             frs1;
	logic [SumW-1:0]         div_sum;
	logic [NpW-1:0]          div_np;
	logic [NpW-33:0]         div_hi;
	logic                    div_ovf;
	logic [15:0]             rem_d;
	logic [DIV_Q_W-1:0]      quo_d;
	logic signed [31:0]      adj_d;
	logic signed [31:0]      cur_vel, cur_lim;
	logic signed [63:0]      drive8;

	// ---- throttle average ----
	assign s8      = {s_q, 8'b0};
	assign diff    = {s8[AvgW-1], s8} - {avg_q[AvgW-1], avg_q};
	assign abs_s   = s_q[SW-1] ? -{s_q[SW-1], s_q} : {s_q[SW-1], s_q};
	assign abs_avg = avg_q[AvgW-1] ? -{avg_q[AvgW-1], avg_q} : {avg_q[AvgW-1], avg_q};
	assign brake   = {abs_s, 9'b0} < {1'b0, abs_avg};
	assign avg_rnd = rnd_shr((64'(avg_q) <<< 16) + 64'(prod_q), 16);
	assign avg_new = brake ? s8 : avg_rnd[AvgW-1:0];

	assign status.dead = 32'(abs_avg) < 32'({db_q, 8'b0});

	// ---- speed and current limit compares ----
	assign pos    = !s_q[SW-1] && (|s_q);
	assign err    = (ErrW'(rpm_q) <<< (SW - 1)) - ErrW'(p1_q);
	assign rpm_sh = CmpW'(rpm_q) <<< (SW + 15);
	assign p2x    = CmpW'(p2_q);
	assign cur_sh = CmpW'(cur_q) <<< (SW - 1);
	assign p3_sh  = CmpW'($signed(prod_q[P3W-1:0])) <<< 8;
	assign vel_c  = (pos ? (rpm_sh > p2x) : (rpm_sh < p2x)) &&
			(pos ? (cur_sh < p3_sh) : (cur_sh > p3_sh));
	assign status.vel = vel_c;

	assign lim8_w   = rnd_shr(64'($signed(prod_q[P3W-1:0])) <<< 8, SW - 1);
	assign lim_diff = MulAW'(lim8_q) - MulAW'(cur_q);

	// ---- shared multiplier operand select ----
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (cmd.op)
			OP_MUL_AVG: begin
				mul_a = MulAW'(diff);
				mul_b = $signed({1'b0, w_q});
			end
			OP_AVG: begin
				mul_a = MulAW'(s_q);
				mul_b = $signed({1'b0, frs_q});
			end
			OP_P1: begin
				mul_a = $signed(prod_q[MulAW-1:0]);
				mul_b = $signed({1'b0, frac_q});
			end
			OP_P3: begin
				mul_a = MulAW'(s_q);
				mul_b = $signed({1'b0, fcu_q});
			end
			OP_DECIDE: begin
				mul_a = MulAW'(err);
				mul_b = $signed({1'b0, fcu_q});
			end
			OP_LIM_MUL: begin
				mul_a = lim_diff;
				mul_b = $signed({1'b0, w_q});
			end
			OP_GAIN_MUL: begin
				mul_a = MulAW'(adj_q);
				mul_b = $signed({1'b0, gain_q});
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

	// ---- divider load: |err*fcu*256| plus half the divisor, shifted right by SW-1 ----
	assign abs_prod = prod_q[ProdW-1] ? ProdW'(-prod_q) : ProdW'(prod_q);
	assign frs1     = (frs_q == '0) ? 16'd1 : frs_q;
	assign div_sum  = {1'b0, abs_prod, 8'b0} + (SumW'(frs1) << (SW - 2));
	assign div_np   = div_sum[SumW-1:SW-1];
	assign div_hi   = div_np[NpW-1:DIV_Q_W];
	assign div_ovf  = 32'(div_hi) >= 32'(frs1);

	// ---- restoring divider steps ----
	always_comb begin
		logic [16:0] t;
		rem_d = rem_q;
		quo_d = quo_q;
		for (int i = 0; i < DIV_BPC; i++) begin
			t     = {rem_d, quo_d[DIV_Q_W-1]};
			quo_d = {quo_d[DIV_Q_W-2:0], 1'b0};
			if (t >= {1'b0, frs1}) begin
				t        = t - {1'b0, frs1};
				quo_d[0] = 1'b1;
			end
			rem_d = t[15:0];
		end
	end

	// ---- signed, saturated adjustment ----
	always_comb begin
		if (neg_q) begin
			if (ovf_q || (quo_q[31] && (|quo_q[30:0]))) begin
				adj_d = INT32_MIN;
			end else begin
				adj_d = -$signed(quo_q);
			end
		end else begin
			if (ovf_q || quo_q[31]) begin
				adj_d = INT32_MAX;
			end else begin
				adj_d = $signed(quo_q);
			end
		end
	end

	assign cur_vel = sat32(64'(cur_q) + rnd_shr(64'(prod_q), 16));
	assign cur_lim = sat32(rnd_shr((64'(cur_q) <<< 16) + 64'(prod_q), 16));
	assign drive8  = vel_q ? 64'(cur_q) + 64'(adj_q) : 64'(cur_q);

	// ---- configuration ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= RST_SMOOTHING_WEIGHT;
			db_q   <= RST_DEADBAND;
			frs_q  <= RST_FULL_SCALE_RPM;
			fcu_q  <= RST_FULL_SCALE_CUR;
			frac_q <= RST_SPEED_FRACTION;
			gain_q <= RST_INTEGRAL_GAIN;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_SMOOTHING_WEIGHT:     w_q    <= cfg_data;
				CFG_DEADBAND:             db_q   <= cfg_data[11:0];
				CFG_FULL_SCALE_RPM:       frs_q  <= cfg_data;
				CFG_FULL_SCALE_CURRENT:   fcu_q  <= cfg_data;
				CFG_SPEED_LIMIT_FRACTION: frac_q <= cfg_data;
				CFG_INTEGRAL_GAIN:        gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---- persistent state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
			cur_q <= '0;
		end else begin
			case (cmd.op)
				OP_AVG:      avg_q <= avg_new;
				OP_DEAD:     cur_q <= '0;
				OP_LIM_DONE: cur_q <= cur_lim;
				OP_VEL_DONE: cur_q <= cur_vel;
				default: ;
			endcase
		end
	end

	// ---- working registers ----
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_p;
		end
		case (cmd.op)
			OP_LOAD: begin
				s_q   <= throttle_sample;
				rpm_q <= motor_rpm;
			end
			OP_P1: begin
				p1_q <= prod_q[P1W-1:0];
			end
			OP_P3: begin
				p2_q <= prod_q[P2W-1:0];
			end
			OP_DECIDE: begin
				vel_q  <= vel_c;
				en_q   <= 1'b1;
				lim8_q <= lim8_w[Lim8W-1:0];
			end
			OP_DEAD: begin
				vel_q <= 1'b0;
				en_q  <= 1'b0;
			end
			OP_DIV_LOAD: begin
				neg_q <= !prod_q[ProdW-1] && (|prod_q);
				ovf_q <= div_ovf;
				rem_q <= div_ovf ? 16'd0 : 16'(div_hi);
				quo_q <= div_np[DIV_Q_W-1:0];
			end
			OP_DIV_STEP: begin
				rem_q <= rem_d;
				quo_q <= quo_d;
			end
			OP_ADJ: begin
				adj_q <= adj_d;
			end
			OP_FINISH: begin
				res_q.motor_enable     <= en_q;
				res_q.drive_current_ma <= sat16(rnd_shr(drive8, 8));
				res_q.velocity_mode    <= vel_q;
				res_q.held_current_ma  <= sat16(rnd_shr(64'(cur_q), 8));
			end
			default: ;
		endcase
	end

	assign result = res_q;

endmodule

// ===== rtl/core/throttle_current_speed_limiter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// throttle_current_speed_limiter_core
// Throttle-driven motor current command with speed limiting.
// ----------------------------------------------------------------------------
// One input item per control tick; one result item per tick whose sample read
// succeeded, none for a failed read. The block handles one tick at a time. A
// tick with a failed read is taken without leaving the idle state. A valid
// tick inside the deadband runs the averaging and deadband steps, a tick in
// current ramp mode the averaging, limit compare and ramp steps, and a tick in
// speed-limit mode the averaging and compare steps, then the divider (2
// quotient bits per cycle) forming the speed error times the current/rpm
// full-scale ratio, then the gain step. The sequencer returns to idle as the
// result is placed in the output register, and then accepts the next item.
// All products go through a single registered multiplier that the sequencer
// time-shares. The output register holds a finished result while the next
// tick is taken and worked on; a tick only stalls at its end if the previous
// result has still not been taken. Configuration writes are applied at once
// and must be made while the block is idle.
// ----------------------------------------------------------------------------
module throttle_current_speed_limiter_core
	import tcsl_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// slave side
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// throttle_sample, sample_valid, motor_rpm (from bit 0), zero padded
	input  logic [((SAMPLE_BITS+17+7)/8)*8-1:0]   s_tdata,
	// master side
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// motor_enable, drive_current_ma, velocity_mode, held_current_ma
	// (from bit 0), zero padded
	output logic [OUT_TDATA_W-1:0]                m_tdata,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [CFG_IDX_W-1:0]                  cfg_index,
	input  logic [CFG_DATA_W-1:0]                 cfg_data
);

	// Unpack the input item
	logic signed [SAMPLE_BITS-1:0] throttle_sample;
	logic                          sample_valid;
	logic signed [15:0]            motor_rpm;

	assign throttle_sample = s_tdata[SAMPLE_BITS-1:0];
	assign sample_valid    = s_tdata[SAMPLE_BITS];
	assign motor_rpm       = s_tdata[SAMPLE_BITS+16:SAMPLE_BITS+1];

	dp_cmd_t      cmd;
	dp_status_t   status;
	tcsl_result_t result;

	// Sequencer: a state per multiplier slot and per update step, plus the divider loop
	tcsl_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_tvalid),
		.in_sample_valid (sample_valid),
		.in_ready        (s_tready),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.status          (status),
		.cmd             (cmd)
	);

	// Arithmetic, state, configuration and result register
	tcsl_dp #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.throttle_sample (throttle_sample),
		.motor_rpm       (motor_rpm),
		.result          (result)
	);

	// Pack the result item, motor_enable in the lowest bit
	assign m_tdata = {{OUT_PAD_W{1'b0}}, result};

endmodule

// ===== verif/throttle_current_speed_limiter_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// throttle_current_speed_limiter_core_tb
// Self-checking bench for the throttle current and speed limiter core.
// ----------------------------------------------------------------------------
// A short directed sequence walks the deadband, fast braking, both throttle
// directions, speed-limit mode, a zero rpm full scale and the saturation of
// the stored and commanded current. Eight register settings follow, extremes
// among them, each with a run of random control ticks that mostly move the
// throttle smoothly and hold the motor near its speed limit. Every result item
// is checked field by field against a bit-exact fixed-point model of the
// limiter kept in this bench. Both stream sides idle at random, and once the
// receiver holds off long enough for the core to stall its input.
// ----------------------------------------------------------------------------
module throttle_current_speed_limiter_core_tb;
	import tcsl_pkg::*;

	localparam int     IN_FIELD_W      = SAMPLE_BITS_DEF + 17;
	localparam int     IN_TDATA_W      = ((IN_FIELD_W + 7) / 8) * 8;
	localparam int     IN_PAD_W        = IN_TDATA_W - IN_FIELD_W;
	localparam longint FULL_THROTTLE   = 2048;
	localparam longint I32_MAX         = 64'sd2147483647;
	localparam longint I32_MIN         = -64'sd2147483648;
	localparam int     SETTLE_CYCLES   = 32;     // outlasts the longest tick
	localparam int     HOLD_OFF_CYCLES = 400;
	localparam int     WATCHDOG_LIMIT  = 4000;
	localparam int     MAX_REPORTS     = 40;
	localparam int     NUM_PHASES      = 8;
	localparam int     NUM_ROWS        = 33;
	localparam int     CORNER_SAMPLES [5] = '{-2048, 2047, 0, -1, 1};

	// One line of the directed sequence: a register write or a control tick
	typedef struct {
		bit                 is_cfg;
		cfg_reg_t           idx;
		logic [15:0]        val;
		logic signed [11:0] smp;
		logic               ok;
		logic signed [15:0] rpm;
		bit                 stop_known;   // result is the all-zero motor stop
	} step_row_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	// throttle_sample, sample_valid, motor_rpm (from bit 0), zero padded
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	// motor_enable, drive_current_ma, velocity_mode, held_current_ma
	// (from bit 0), zero padded
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// Model state: register copies, smoothed throttle and stored current (Q.8)
	logic [15:0]        cfg_shadow [6];
	logic signed [23:0] throttle_avg_q8;
	logic signed [31:0] stored_current_q8;

	tcsl_result_t expected_results [$];

	int  mismatch_count   = 0;
	int  ticks_sent       = 0;
	int  failed_reads     = 0;
	int  settings_written = 0;
	int  results_seen     = 0;
	int  speed_mode_seen  = 0;
	int  stopped_seen     = 0;
	int  quiet_cycles     = 0;
	bit  gaps_on          = 1'b1;
	bit  hold_off_req     = 1'b0;

	always #10 clk = ~clk;

	throttle_current_speed_limiter_core #(
		.SAMPLE_BITS(SAMPLE_BITS_DEF)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// ------------------------------------------------------------------
	// Fixed-point helpers of the model
	// ------------------------------------------------------------------

	// Divide, round to nearest with ties away from zero; d is positive
	function automatic longint div_round(input longint n, input longint d);
		longint a;
		longint q;
		a = (n < 0) ? -n : n;
		q = (a + d / 2) / d;
		return (n < 0) ? -q : q;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint mag(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Advance the model by one control tick; returns 1 when a result is due
	function automatic bit limiter_step(input logic signed [11:0] smp, input logic ok,
			input logic signed [15:0] rpm, output tcsl_result_t res);
		longint s, r, w, a, c, fr, fc, frac, gain, db, dir, den, err, adj, drv;
		bit     vel;
		res = '0;
		if (!ok) begin
			return 1'b0;
		end
		s    = longint'(smp);
		r    = longint'(rpm);
		w    = longint'(cfg_shadow[CFG_SMOOTHING_WEIGHT]);
		db   = longint'(cfg_shadow[CFG_DEADBAND]);
		fr   = longint'(cfg_shadow[CFG_FULL_SCALE_RPM]);
		fc   = longint'(cfg_shadow[CFG_FULL_SCALE_CURRENT]);
		frac = longint'(cfg_shadow[CFG_SPEED_LIMIT_FRACTION]);
		gain = longint'(cfg_shadow[CFG_INTEGRAL_GAIN]);

		// Fast braking snaps the average to the sample, else smooth it
		a = longint'(throttle_avg_q8);
		if (mag(s) * 512 < mag(a)) begin
			a = s * 256;
		end else begin
			a = div_round(w * s * 256 + (65536 - w) * a, 65536);
		end
		throttle_avg_q8 = 24'(a);

		// Inside the deadband: stop the motor and drop the stored current
		if (mag(a) < db * 256) begin
			stored_current_q8 = '0;
			return 1'b1;
		end

		dir = (s > 0) ? 1 : -1;
		c   = longint'(stored_current_q8);
		vel = 1'b0;
		if (dir * r * FULL_THROTTLE * 65536 > dir * fr * s * frac &&
				dir * c * FULL_THROTTLE < dir * fc * s * 256) begin
			// Speed-limit mode: trim by the speed error scaled by the full-scale ratio
			den = ((fr == 0) ? 1 : fr) * FULL_THROTTLE;
			err = r * FULL_THROTTLE - fr * s;
			adj = clip(div_round(-err * fc * 256, den), I32_MIN, I32_MAX);
			c   = clip(c + div_round(adj * gain, 65536), I32_MIN, I32_MAX);
			drv = c + adj;
			vel = 1'b1;
		end else begin
			// Ramp the stored current toward the throttle-scaled limit
			c   = clip(div_round(w * div_round(fc * s * 256, FULL_THROTTLE)
				+ (65536 - w) * c, 65536), I32_MIN, I32_MAX);
			drv = c;
		end
		stored_current_q8 = 32'(c);

		res.motor_enable     = 1'b1;
		res.drive_current_ma = 16'(clip(div_round(drv, 256), -32768, 32767));
		res.velocity_mode    = vel;
		res.held_current_ma  = 16'(clip(div_round(c, 256), -32768, 32767));
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Directed rows
	// ------------------------------------------------------------------

	function automatic step_row_t tick_row(input logic signed [11:0] smp, input logic ok,
			input logic signed [15:0] rpm, input bit stop_known);
		step_row_t row;
		row.is_cfg     = 1'b0;
		row.idx        = CFG_SMOOTHING_WEIGHT;
		row.val        = '0;
		row.smp        = smp;
		row.ok         = ok;
		row.rpm        = rpm;
		row.stop_known = stop_known;
		return row;
	endfunction

	function automatic step_row_t cfg_row(input cfg_reg_t idx, input logic [15:0] val);
		step_row_t row;
		row.is_cfg     = 1'b1;
		row.idx        = idx;
		row.val        = val;
		row.smp        = '0;
		row.ok         = 1'b0;
		row.rpm        = '0;
		row.stop_known = 1'b0;
		return row;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus tasks
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("MISMATCH: %s", msg);
		end
	endtask

	// Offer one tick, hold it until taken, then predict its result
	task automatic send_tick(input logic signed [11:0] smp, input logic ok,
			input logic signed [15:0] rpm, input bit stop_known);
		int           gap;
		bit           has_res;
		tcsl_result_t res;
		// Switch idling on and off in stretches so gap-free runs occur too
		if (ticks_sent % 40 == 0) begin
			gaps_on = ($urandom_range(0, 2) != 0);
		end
		gap = gaps_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{IN_PAD_W{1'b0}}, rpm, ok, smp};
		do @(posedge clk); while (!(s_tvalid && s_tready));
		ticks_sent++;
		if (!ok) begin
			failed_reads++;
		end
		has_res = limiter_step(smp, ok, rpm, res);
		if (has_res) begin
			expected_results.push_back(stop_known ? tcsl_result_t'('0) : res);
		end
	endtask

	// Drop valid, drain all results, then give a failed-read tick time to end
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cfg_shadow[idx] = (idx == CFG_DEADBAND) ? (val & 16'h0FFF) : val;
		settings_written++;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		step_row_t          rows [NUM_ROWS];
		logic [15:0]        phase_cfg [6];
		logic signed [11:0] smp;
		logic signed [15:0] rpm;
		longint             walk;
		longint             spd;
		int                 n_items;

		// Reset state of the model
		cfg_shadow[CFG_SMOOTHING_WEIGHT]     = RST_SMOOTHING_WEIGHT;
		cfg_shadow[CFG_DEADBAND]             = RST_DEADBAND;
		cfg_shadow[CFG_FULL_SCALE_RPM]       = RST_FULL_SCALE_RPM;
		cfg_shadow[CFG_FULL_SCALE_CURRENT]   = RST_FULL_SCALE_CUR;
		cfg_shadow[CFG_SPEED_LIMIT_FRACTION] = RST_SPEED_FRACTION;
		cfg_shadow[CFG_INTEGRAL_GAIN]        = RST_INTEGRAL_GAIN;
		throttle_avg_q8   = '0;
		stored_current_q8 = '0;
		walk              = 0;

		rows = '{
			// Reset values: zero throttle sits in the deadband
			tick_row(12'sd0, 1'b1, 16'sd0, 1'b1),
			// Failed reads give nothing and change nothing
			tick_row(12'sd2047, 1'b0, 16'sd0, 1'b0),
			tick_row(-12'sd2048, 1'b0, -16'sd32768, 1'b0),
			// Full forward throttle: ramp, then speed limiting
			tick_row(12'sd2047, 1'b1, 16'sd0, 1'b0),
			tick_row(12'sd2047, 1'b1, 16'sd0, 1'b0),
			tick_row(12'sd2047, 1'b1, 16'sd1000, 1'b0),
			tick_row(12'sd2047, 1'b1, 16'sd32767, 1'b0),
			tick_row(12'sd2047, 1'b1, 16'sd32767, 1'b0),
			// Fast braking lands the average inside the deadband
			tick_row(12'sd100, 1'b1, 16'sd0, 1'b1),
			// Full reverse throttle
			tick_row(-12'sd2048, 1'b1, 16'sd0, 1'b0),
			tick_row(-12'sd2048, 1'b1, -16'sd32768, 1'b0),
			tick_row(-12'sd2048, 1'b1, 16'sd32767, 1'b0),
			// Zero sample brakes the average straight to zero
			tick_row(12'sd0, 1'b1, -16'sd32768, 1'b1),
			// No deadband, newest value only: a zero sample counts as reverse
			cfg_row(CFG_DEADBAND, 16'd0),
			cfg_row(CFG_SMOOTHING_WEIGHT, 16'd65535),
			tick_row(12'sd0, 1'b1, 16'sd100, 1'b0),
			tick_row(12'sd0, 1'b1, -16'sd5000, 1'b0),
			// Zero rpm full scale: the ratio falls back to a divisor of one
			cfg_row(CFG_FULL_SCALE_RPM, 16'd0),
			tick_row(12'sd1000, 1'b1, 16'sd5000, 1'b0),
			tick_row(12'sd1000, 1'b1, 16'sd5000, 1'b0),
			// Huge corrections: saturate the drive and the stored current
			cfg_row(CFG_FULL_SCALE_RPM, 16'd1),
			cfg_row(CFG_FULL_SCALE_CURRENT, 16'd65535),
			cfg_row(CFG_INTEGRAL_GAIN, 16'd65535),
			cfg_row(CFG_SPEED_LIMIT_FRACTION, 16'd0),
			tick_row(12'sd2047, 1'b1, 16'sd32767, 1'b0),
			tick_row(12'sd2047, 1'b1, 16'sd32767, 1'b0),
			tick_row(12'sd2047, 1'b1, 16'sd32767, 1'b0),
			tick_row(-12'sd2048, 1'b1, -16'sd32768, 1'b0),
			tick_row(-12'sd2048, 1'b1, -16'sd32768, 1'b0),
			tick_row(-12'sd2048, 1'b1, -16'sd32768, 1'b0),
			// Frozen average: only fast braking moves it
			cfg_row(CFG_SMOOTHING_WEIGHT, 16'd0),
			tick_row(-12'sd1, 1'b1, -16'sd1, 1'b0),
			tick_row(12'sd1, 1'b1, 16'sd1, 1'b0)
		};

		// Hold reset, then release it on a clock edge
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				wait_quiet();
				write_reg(rows[i].idx, rows[i].val);
			end else begin
				send_tick(rows[i].smp, rows[i].ok, rows[i].rpm, rows[i].stop_known);
			end
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: phase_cfg = '{RST_SMOOTHING_WEIGHT, RST_DEADBAND, RST_FULL_SCALE_RPM,
					RST_FULL_SCALE_CUR, RST_SPEED_FRACTION, RST_INTEGRAL_GAIN};
				1: phase_cfg = '{16'd65535, 16'd0, 16'd65535, 16'd65535, 16'd65535, 16'd65535};
				// Widest deadband: the motor runs only with the average at full reverse
				2: phase_cfg = '{16'd0, 16'd2048, 16'd1, 16'd1, 16'd0, 16'd0};
				3: phase_cfg = '{16'd1, 16'd0, 16'd1, 16'd1, 16'd0, 16'd0};
				default: phase_cfg = '{16'($urandom), 16'($urandom_range(0, 400)),
					16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
					16'($urandom), 16'($urandom)};
			endcase
			wait_quiet();
			for (int k = 0; k < 6; k++) begin
				write_reg(cfg_reg_t'(k), phase_cfg[k]);
			end
			// Ask the receiver for one long hold-off while ticks keep coming
			if (p == 4) begin
				hold_off_req = 1'b1;
			end
			n_items = (p == 2) ? 40 : ((p < 4) ? 100 : 115);
			for (int k = 0; k < n_items; k++) begin
				// Throttle mostly drifts; sometimes jumps anywhere or to a corner
				case ($urandom_range(0, 9))
					0, 1: begin
						smp  = 12'($urandom);
						walk = longint'(smp);
					end
					2: walk = longint'(CORNER_SAMPLES[$urandom_range(0, 4)]);
					default: walk = clip(walk + longint'($urandom_range(0, 200)) - 100,
						-2048, 2047);
				endcase
				smp = 12'(walk);
				// Keep the motor near the throttle's speed limit most of the time
				if ($urandom_range(0, 3) == 0) begin
					rpm = 16'($urandom);
				end else begin
					spd = longint'(cfg_shadow[CFG_FULL_SCALE_RPM]) * walk / FULL_THROTTLE;
					spd = spd * longint'($urandom_range(80, 120)) / 100
						+ longint'($urandom_range(0, 64)) - 32;
					rpm = 16'(clip(spd, -32768, 32767));
				end
				send_tick(smp, ($urandom_range(0, 9) != 0), rpm, 1'b0);
			end
		end

		wait_quiet();
		$display("Ran %0d ticks (%0d failed reads) under %0d register writes.",
			ticks_sent, failed_reads, settings_written);
		$display("Checked %0d results: %0d speed-limited, %0d stopped, %0d mismatches.",
			results_seen, speed_mode_seen, stopped_seen, mismatch_count);
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// Result side: random stalls, one long hold-off, field checks
	// ------------------------------------------------------------------
	initial begin : result_sink
		int           stall;
		bit           stall_on;
		tcsl_result_t got;
		tcsl_result_t want;
		string        diff;

		stall_on = 1'b1;
		while (!arst_n) @(posedge clk);
		forever begin
			if (results_seen % 40 == 0) begin
				stall_on = ($urandom_range(0, 2) != 0);
			end
			stall = stall_on ? $urandom_range(0, 16) : 0;
			if (hold_off_req) begin
				// Hold long enough for the core to fill and stall its input
				hold_off_req = 1'b0;
				stall        = HOLD_OFF_CYCLES;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			got = m_tdata[OUT_FIELD_W-1:0];
			results_seen++;
			if (got.velocity_mode) begin
				speed_mode_seen++;
			end
			if (!got.motor_enable) begin
				stopped_seen++;
			end
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing expected",
					results_seen));
			end else begin
				want = expected_results.pop_front();
				diff = "";
				if (got.motor_enable !== want.motor_enable) begin
					diff = {diff, $sformatf(" enable %0d/%0d", got.motor_enable,
						want.motor_enable)};
				end
				if (got.drive_current_ma !== want.drive_current_ma) begin
					diff = {diff, $sformatf(" drive %0d/%0d", got.drive_current_ma,
						want.drive_current_ma)};
				end
				if (got.velocity_mode !== want.velocity_mode) begin
					diff = {diff, $sformatf(" velocity %0d/%0d", got.velocity_mode,
						want.velocity_mode)};
				end
				if (got.held_current_ma !== want.held_current_ma) begin
					diff = {diff, $sformatf(" held %0d/%0d", got.held_current_ma,
						want.held_current_ma)};
				end
				if (diff != "") begin
					report_mismatch($sformatf("result %0d (got/expected):%s",
						results_seen, diff));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run when no item moves for too long
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
				quiet_cycles, expected_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
rtl/core/tcsl_pkg.sv
rtl/core/tcsl_ctrl.sv
rtl/core/tcsl_dp.sv
rtl/core/throttle_current_speed_limiter_core.sv
verif/throttle_current_speed_limiter_core_tb.sv
